// ===== hw/rtl/nas_alloc_pkg.sv =====
// shared types, codes and unit arithmetic of the nested arena stack allocator
`default_nettype none

package nas_alloc_pkg;

	// unit arithmetic: bytes are counted in 16-byte units
	localparam int ALIGN_SHIFT     = 4;
	localparam int SIZE_W          = 32;
	localparam int OFFSET_W        = 32;
	localparam int UNIT_W          = SIZE_W + 1 - ALIGN_SHIFT;
	localparam int MIN_ARENA_BYTES = 64;
	localparam int ALIGN_BYTES     = 1 << ALIGN_SHIFT;
	localparam logic [UNIT_W-1:0] MIN_ARENA_UNITS =
		UNIT_W'((MIN_ARENA_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES);

	typedef enum logic [2:0] {
		OP_ENTER   = 3'd0,
		OP_EXIT    = 3'd1,
		OP_ALLOC   = 3'd2,
		OP_RESET   = 3'd3,
		OP_CLEANUP = 3'd4
	} opcode_e_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_FULL       = 3'd1,
		STAT_BAD_SIZE   = 3'd2,
		STAT_EMPTY      = 3'd3,
		STAT_NO_SPACE   = 3'd4,
		STAT_ZERO_ALLOC = 3'd5
	} status_e_t;

	// one arena frame record
	typedef struct packed {
		logic [UNIT_W-1:0] cap;
		logic [UNIT_W-1:0] used;
		logic [UNIT_W-1:0] peak;
	} frame_t;

	// what one operation does to the stack
	typedef struct packed {
		status_e_t           status;
		logic [OFFSET_W-1:0] offset;
		logic [UNIT_W-1:0]   popped;
		frame_t              top;
		logic                mem_wr;
		logic                need_load;
	} op_res_t;

	// round a byte count up to whole units
	function automatic logic [UNIT_W-1:0] units_up(input logic [SIZE_W-1:0] bytes);
		logic [SIZE_W:0] sum;
		sum = {1'b0, bytes} + (SIZE_W + 1)'(ALIGN_BYTES - 1);
		return sum[SIZE_W:ALIGN_SHIFT];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nested_arena_stack_allocator_core.sv =====
// top level of the nested arena stack allocator
// A stack of up to MAX_FRAMES arena frames, each with a capacity, a used
// amount and a peak, all in 16-byte units. Each input word carries an
// opcode (enter, exit, alloc, reset top, cleanup) and a byte size, and
// produces exactly one result word with a status, the allocation offset,
// the new depth and the top frame's used and capacity counts. The top
// frame lives in registers and the frames below it in a one-port-write,
// one-port-read synchronous memory. An exit that leaves frames on the
// stack reads the new top frame back from memory in a load state, so the
// block takes one word per cycle unless the result channel stalls, but
// takes no new word during such a load. The frame memory needs no
// clearing after reset; the block is ready at once.
`default_nettype none

module nested_arena_stack_allocator_core #(
	parameter int MAX_FRAMES = 64,
	localparam int DEPTH_W   = $clog2(MAX_FRAMES + 1)
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input word channel
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [2:0]                             opcode,
	input  wire logic [nas_alloc_pkg::SIZE_W-1:0]       req_bytes,
	// result word channel
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [2:0]                                  status,
	output logic [nas_alloc_pkg::OFFSET_W-1:0]          alloc_offset,
	output logic [DEPTH_W-1:0]                          depth_now,
	output logic [nas_alloc_pkg::UNIT_W-1:0]            top_used_units,
	output logic [nas_alloc_pkg::UNIT_W-1:0]            top_capacity_units,
	output logic [nas_alloc_pkg::UNIT_W-1:0]            popped_peak_units
);

	localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	// run: take words; load: new top frame arrives from memory
	typedef enum logic [1:0] {
		S_RUN  = 2'b01,
		S_LOAD = 2'b10
	} fsm_t;

	fsm_t                              state_q;
	logic [DEPTH_W-1:0]                depth_q;
	nas_alloc_pkg::frame_t             top_q;

	// output register
	logic                              out_valid_q;
	logic [2:0]                        status_q;
	logic [nas_alloc_pkg::OFFSET_W-1:0] offset_q;
	logic [DEPTH_W-1:0]                depth_out_q;
	logic [nas_alloc_pkg::UNIT_W-1:0]  used_out_q;
	logic [nas_alloc_pkg::UNIT_W-1:0]  cap_out_q;
	logic [nas_alloc_pkg::UNIT_W-1:0]  popped_out_q;

	logic                              out_free;
	logic                              acc;
	logic [DEPTH_W-1:0]                nxt_depth;
	nas_alloc_pkg::op_res_t            res;
	nas_alloc_pkg::frame_t             rd_data;
	logic                              mem_wr;
	logic                              mem_rd;
	logic [ADDR_W-1:0]                 wr_addr;
	logic [ADDR_W-1:0]                 rd_addr;
	logic                              nxt_nonempty;

	// result slot is free if empty or being drained this edge
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_RUN) && out_free);
	assign acc      = in_valid && !in_stall;

	nas_alloc_op_unit #(
		.MAX_FRAMES (MAX_FRAMES),
		.DEPTH_W    (DEPTH_W)
	) u_op (
		.opcode     (opcode),
		.req_bytes  (req_bytes),
		.depth      (depth_q),
		.top        (top_q),
		.nxt_depth  (nxt_depth),
		.res        (res)
	);

	// enter spills the old top to slot depth-1; exit fetches slot depth-2
	assign mem_wr  = acc && res.mem_wr;
	assign mem_rd  = acc && res.need_load;
	assign wr_addr = ADDR_W'(depth_q - DEPTH_W'(1));
	assign rd_addr = ADDR_W'(depth_q - DEPTH_W'(2));

	nas_alloc_frame_mem #(
		.DEPTH  (MAX_FRAMES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (wr_addr),
		.wr_data (top_q),
		.rd_en   (mem_rd),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign nxt_nonempty = (nxt_depth != '0);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_RUN: begin
					if (acc) begin
						depth_q <= nxt_depth;
						if (res.need_load) begin
							// result waits for the memory read
							state_q     <= S_LOAD;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (!out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				S_LOAD: begin
					state_q     <= S_RUN;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	// top frame record and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			top_q      <= rd_data;
			used_out_q <= rd_data.used;
			cap_out_q  <= rd_data.cap;
		end else if (acc) begin
			top_q        <= res.top;
			status_q     <= res.status;
			offset_q     <= res.offset;
			depth_out_q  <= nxt_depth;
			popped_out_q <= res.popped;
			used_out_q   <= nxt_nonempty ? res.top.used : '0;
			cap_out_q    <= nxt_nonempty ? res.top.cap : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign alloc_offset       = offset_q;
	assign depth_now          = depth_out_q;
	assign top_used_units     = used_out_q;
	assign top_capacity_units = cap_out_q;
	assign popped_peak_units  = popped_out_q;

`ifndef ASSERT_OFF
	// the result slot stays empty while a memory load is pending
	a_load_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !out_valid_q)
		else $error("result slot busy during frame load");

	// an exit that leaves frames on the stack always goes through a load
	a_exit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res.need_load) |=> (state_q == S_LOAD))
		else $error("frame load skipped after exit");

	// a new result only appears after an accepted word or a load
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(acc || (state_q == S_LOAD)))
		else $error("result word without a source");

	// frame store is never written and read in the same cycle
	a_mem_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr && mem_rd))
		else $error("frame store write and read collide");

	// stack depth stays within bounds
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_FRAMES))
		else $error("stack depth out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/nas_alloc_frame_mem.sv =====
// frame record store for the frames below the top of the stack
`default_nettype none

module nas_alloc_frame_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [ADDR_W-1:0]     wr_addr,
	input  wire nas_alloc_pkg::frame_t wr_data,
	input  wire logic                  rd_en,
	input  wire logic [ADDR_W-1:0]     rd_addr,
	output nas_alloc_pkg::frame_t      rd_data
);

	nas_alloc_pkg::frame_t mem_q [DEPTH];
	nas_alloc_pkg::frame_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/nas_alloc_op_unit.sv =====
// operation decode and top-frame arithmetic
`default_nettype none

module nas_alloc_op_unit #(
	parameter int MAX_FRAMES = 64,
	parameter int DEPTH_W    = 7
) (
	input  wire logic [2:0]                       opcode,
	input  wire logic [nas_alloc_pkg::SIZE_W-1:0] req_bytes,
	input  wire logic [DEPTH_W-1:0]               depth,
	input  wire nas_alloc_pkg::frame_t            top,
	output logic [DEPTH_W-1:0]                    nxt_depth,
	output nas_alloc_pkg::op_res_t                res
);

	localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_FRAMES);
	localparam logic [DEPTH_W-1:0] ONE_D = DEPTH_W'(1);

	logic [nas_alloc_pkg::UNIT_W-1:0]  need;
	logic [nas_alloc_pkg::UNIT_W:0]    used_sum;
	logic [nas_alloc_pkg::UNIT_W+nas_alloc_pkg::ALIGN_SHIFT-1:0] off_wide;
	logic                              size_zero;
	logic                              empty;

	assign need      = nas_alloc_pkg::units_up(req_bytes);
	assign used_sum  = {1'b0, top.used} + {1'b0, need};
	assign off_wide  = {top.used, {nas_alloc_pkg::ALIGN_SHIFT{1'b0}}};
	assign size_zero = (req_bytes == '0);
	assign empty     = (depth == '0);

	always_comb begin
		res        = '0;
		res.status = nas_alloc_pkg::STAT_OK;
		res.top    = top;
		nxt_depth  = depth;
		case (opcode)
			nas_alloc_pkg::OP_ENTER: begin
				if (depth >= MAX_D) begin
					res.status = nas_alloc_pkg::STAT_FULL;
				end else if (size_zero) begin
					res.status = nas_alloc_pkg::STAT_BAD_SIZE;
				end else begin
					// old top spills to the store
					res.mem_wr   = !empty;
					res.top.cap  = (need < nas_alloc_pkg::MIN_ARENA_UNITS) ?
						nas_alloc_pkg::MIN_ARENA_UNITS : need;
					res.top.used = '0;
					res.top.peak = '0;
					nxt_depth    = depth + ONE_D;
				end
			end
			nas_alloc_pkg::OP_EXIT: begin
				if (empty) begin
					res.status = nas_alloc_pkg::STAT_EMPTY;
				end else begin
					res.popped    = top.peak;
					res.need_load = (depth != ONE_D);
					nxt_depth     = depth - ONE_D;
				end
			end
			nas_alloc_pkg::OP_ALLOC: begin
				if (empty) begin
					res.status = nas_alloc_pkg::STAT_EMPTY;
				end else if (size_zero) begin
					res.status = nas_alloc_pkg::STAT_ZERO_ALLOC;
				end else if (used_sum > {1'b0, top.cap}) begin
					res.status = nas_alloc_pkg::STAT_NO_SPACE;
				end else begin
					res.offset   = off_wide[nas_alloc_pkg::OFFSET_W-1:0];
					res.top.used = used_sum[nas_alloc_pkg::UNIT_W-1:0];
					if (used_sum[nas_alloc_pkg::UNIT_W-1:0] > top.peak) begin
						res.top.peak = used_sum[nas_alloc_pkg::UNIT_W-1:0];
					end
				end
			end
			nas_alloc_pkg::OP_RESET: begin
				if (empty) begin
					res.status = nas_alloc_pkg::STAT_EMPTY;
				end else begin
					res.top.used = '0;
				end
			end
			nas_alloc_pkg::OP_CLEANUP: begin
				nxt_depth = '0;
			end
			default: begin
				// unused opcodes leave everything as is
			end
		endcase
	end

endmodule

`default_nettype wire
